[hw/rtl/sbps_pkg.sv]
`timescale 1ns / 1ps
package sbps_pkg;

	localparam int unsigned MaxServosDef  = 8;
	localparam int unsigned QueueDepthDef = 8;
	localparam int unsigned MaxResults    = 4;
	localparam logic [3:0]  MissSat       = 4'd15;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_ENQUEUE = 2'd1,
		OP_DONE    = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		RK_REQUEST = 2'd0,
		RK_EVENT   = 2'd1,
		RK_ERROR   = 2'd2
	} result_kind_t;

	typedef enum logic [2:0] {
		RQ_CMD    = 3'd0,
		RQ_PING   = 3'd1,
		RQ_RAM    = 3'd2,
		RQ_EEP    = 3'd3,
		RQ_TORQUE = 3'd4
	} request_kind_t;

	typedef enum logic [2:0] {
		EV_CONNECTED    = 3'd0,
		EV_DISCONNECTED = 3'd1,
		EV_RAM          = 3'd2,
		EV_ALERT        = 3'd3,
		EV_EEP          = 3'd4
	} event_kind_t;

	typedef enum logic [1:0] {
		ER_OVERRUN    = 2'd0,
		ER_QUEUE_FULL = 2'd1,
		ER_UNKNOWN_ID = 2'd2,
		ER_CMD_FAILED = 2'd3
	} err_code_t;

	typedef enum logic [2:0] {
		AW_NONE    = 3'd0,
		AW_CMD     = 3'd1,
		AW_PING    = 3'd2,
		AW_POLLRAM = 3'd3,
		AW_EEP     = 3'd4,
		AW_RAM     = 3'd5,
		AW_TORQUE  = 3'd6
	} await_t;

	typedef enum logic [2:0] {
		CFG_NUM_SERVOS  = 3'd0,
		CFG_ID_LIST     = 3'd1,
		CFG_MAX_MISSED  = 3'd2,
		CFG_MODEL       = 3'd3
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_SEARCH,
		ST_EMIT
	} back_state_t;

	// One classified input item as it travels from the front to the back part.
	typedef struct packed {
		op_t        op;
		logic       cmd_kind;
		logic [7:0] cmd_servo_id;
		logic [7:0] cmd_tag;
		logic       resp_error;
		logic       resp_alert;
		logic       model_ok;
	} work_t;

	typedef struct packed {
		result_kind_t  result_kind;
		request_kind_t request_kind;
		event_kind_t   event_kind;
		err_code_t     err_code;
		logic [7:0]    servo_id;
		logic [7:0]    out_tag;
	} result_t;

	function automatic result_t mk_req(request_kind_t k, logic [7:0] id, logic [7:0] tag);
		result_t r;
		r = '0;
		r.result_kind  = RK_REQUEST;
		r.request_kind = k;
		r.servo_id     = id;
		r.out_tag      = tag;
		return r;
	endfunction

	function automatic result_t mk_ev(event_kind_t k, logic [7:0] id);
		result_t r;
		r = '0;
		r.result_kind = RK_EVENT;
		r.event_kind  = k;
		r.servo_id    = id;
		return r;
	endfunction

	function automatic result_t mk_err(err_code_t k, logic [7:0] id);
		result_t r;
		r = '0;
		r.result_kind = RK_ERROR;
		r.err_code    = k;
		r.servo_id    = id;
		return r;
	endfunction

endpackage

[hw/rtl/sbps_front.sv]
`timescale 1ns / 1ps
module sbps_front
	import sbps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic        cmd_kind,
	input  logic [7:0]  cmd_servo_id,
	input  logic [7:0]  cmd_tag,
	input  logic        resp_error,
	input  logic        resp_alert,
	input  logic [15:0] resp_model,
	input  logic [15:0] expected_model,
	output logic        work_valid,
	input  logic        work_ready,
	output work_t       work
);

	// Two-entry queue between the front and the back part.
	work_t     q_q [2];
	logic      wp_q, rp_q;
	logic [1:0] cnt_q;
	work_t     cls;

	assign in_ready   = (cnt_q != 2'd2);
	assign work_valid = (cnt_q != 2'd0);
	assign work       = q_q[rp_q];

	always_comb begin
		cls              = '0;
		cls.op           = op_t'(op);
		cls.cmd_kind     = cmd_kind;
		cls.cmd_servo_id = cmd_servo_id;
		cls.cmd_tag      = cmd_tag;
		cls.resp_error   = resp_error;
		cls.resp_alert   = resp_alert;
		cls.model_ok     = (resp_model == expected_model);
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			q_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) begin
				wp_q <= ~wp_q;
			end
			if (work_valid && work_ready) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'((in_valid && in_ready) ? 1 : 0)
				- 2'((work_valid && work_ready) ? 1 : 0);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("front queue count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> !in_ready)
		else $error("front queue accepted while full");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 && !(in_valid && in_ready)) |=> !work_valid)
		else $error("front queue invented an item");

endmodule

[hw/rtl/sbps_back.sv]
`timescale 1ns / 1ps
module sbps_back
	import sbps_pkg::*;
#(
	parameter int unsigned MAX_SERVOS  = MaxServosDef,
	parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        work_valid,
	output logic        work_ready,
	input  work_t       work,
	input  logic [3:0]  num_servos,
	input  logic [63:0] servo_id_list,
	input  logic [3:0]  max_missed,
	output logic        out_valid,
	input  logic        out_ready,
	output result_t     res,
	output logic        last
);

	localparam int unsigned SW = (MAX_SERVOS > 1) ? $clog2(MAX_SERVOS) : 1;
	localparam int unsigned QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned LW = $clog2(QUEUE_DEPTH + 1);

	back_state_t state_q, state_d;

	logic [MAX_SERVOS-1:0] conn_q, tried_q, alert_q;
	logic [3:0]            missed_q [MAX_SERVOS];
	logic [3:0]            pidx_q;
	logic                  pact_q, ppend_q, busy_q;
	await_t                aw_q;
	logic [16:0]           fifo_mem [QUEUE_DEPTH];
	logic [QW-1:0]         rd_q, wr_q;
	logic [LW-1:0]         lvl_q;
	logic [16:0]           cur_q;

	// Result buffer for the item in hand.
	result_t     rbuf_q [MaxResults];
	logic [2:0]  rn_q, ri_q;

	// Id search for a queued EEPROM read.
	logic [3:0]  sk_q;
	logic        found_q;

	logic [3:0]  cnt_eff;
	logic [SW-1:0] si;
	logic [7:0]  sid;
	logic [16:0] fifo_head;

	assign cnt_eff   = (num_servos > 4'(MAX_SERVOS)) ? 4'(MAX_SERVOS) : num_servos;
	assign si        = pidx_q[SW-1:0];
	assign sid       = servo_id_list[{3'(si), 3'b000} +: 8];
	assign fifo_head = fifo_mem[rd_q];

	function automatic logic [QW-1:0] qinc(logic [QW-1:0] p);
		if (32'(p) == QUEUE_DEPTH - 1) begin
			return '0;
		end
		return p + QW'(1);
	endfunction

	// Next-state values computed in DECIDE.
	logic [MAX_SERVOS-1:0] conn_n, tried_n, alert_n;
	logic [3:0]            miss_n;
	logic                  miss_we;
	logic [3:0]            pidx_n;
	logic                  pact_n, ppend_n, busy_n;
	await_t                aw_n;
	logic [QW-1:0]         rd_n, wr_n;
	logic [LW-1:0]         lvl_n;
	logic [16:0]           cur_n;
	logic                  fifo_we;
	result_t               rb_n [MaxResults];
	logic [2:0]            rn_n;
	logic                  go_search;

	always_comb begin
		logic [3:0] m;
		logic       ps;
		logic       done_servo;
		logic [2:0] n;
		logic [7:0] hid;
		logic [SW-1:0] ci;
		logic [7:0] cid;
		logic       run_cmd;
		conn_n = conn_q; tried_n = tried_q; alert_n = alert_q;
		miss_n = missed_q[si]; miss_we = 1'b0;
		pidx_n = pidx_q; pact_n = pact_q; ppend_n = ppend_q; busy_n = busy_q;
		aw_n = aw_q; rd_n = rd_q; wr_n = wr_q; lvl_n = lvl_q; cur_n = cur_q;
		fifo_we = 1'b0; go_search = 1'b0;
		for (int k = 0; k < MaxResults; k++) begin
			rb_n[k] = '0;
		end
		n = 3'd0; ps = 1'b0; done_servo = 1'b0; run_cmd = 1'b0;
		m = missed_q[si];
		hid = fifo_head[15:8];
		ci = '0;
		cid = '0;
		case (work.op)
			OP_TICK: begin
				if (pact_q || ppend_q) begin
					rb_n[0] = mk_err(ER_OVERRUN, 8'd0); n = 3'd1;
				end else begin
					pidx_n = 4'd0;
					if (!busy_q) begin
						busy_n = 1'b1; pact_n = 1'b1; ps = 1'b1;
					end else begin
						ppend_n = 1'b1;
					end
				end
			end
			OP_ENQUEUE: begin
				if (32'(lvl_q) >= QUEUE_DEPTH) begin
					rb_n[0] = mk_err(ER_QUEUE_FULL, work.cmd_servo_id); n = 3'd1;
				end else begin
					fifo_we = 1'b1;
					wr_n = qinc(wr_q);
					lvl_n = lvl_q + LW'(1);
					if (!busy_q) begin
						busy_n = 1'b1;
						// The new item is the head when the queue was empty.
						aw_n = AW_CMD; cur_n = {work.cmd_kind, work.cmd_servo_id, work.cmd_tag};
						lvl_n = lvl_q; rd_n = qinc(rd_q);
						rb_n[0] = mk_req(RQ_CMD, work.cmd_servo_id, work.cmd_tag); n = 3'd1;
					end
				end
			end
			OP_DONE: begin
				case (aw_q)
					AW_CMD: begin
						cid = cur_q[15:8];
						if (work.resp_error) begin
							rb_n[0] = mk_err(ER_CMD_FAILED, cid); n = 3'd1; run_cmd = 1'b1;
						end else if (cur_q[16]) begin
							go_search = 1'b1;
						end else begin
							run_cmd = 1'b1;
						end
					end
					AW_PING: begin
						if (work.resp_error || !work.model_ok) begin
							done_servo = 1'b1;
						end else begin
							aw_n = AW_EEP; rb_n[0] = mk_req(RQ_EEP, sid, 8'd0); n = 3'd1;
						end
					end
					AW_POLLRAM: begin
						if (work.resp_error) begin
							if (m < MissSat) m = m + 4'd1;
							miss_n = m; miss_we = 1'b1;
							if (m >= max_missed) begin
								conn_n[si] = 1'b0;
								rb_n[0] = mk_ev(EV_DISCONNECTED, sid); n = 3'd1;
							end
							done_servo = 1'b1;
						end else if (lvl_q != '0) begin
							pact_n = 1'b0; ppend_n = 1'b1; run_cmd = 1'b1;
						end else begin
							miss_n = 4'd0; miss_we = 1'b1;
							rb_n[0] = mk_ev(EV_RAM, sid); n = 3'd1;
							if (work.resp_alert) begin
								if (!alert_q[si]) begin
									rb_n[1] = mk_ev(EV_ALERT, sid); n = 3'd2;
									alert_n[si] = 1'b1;
								end
							end else begin
								alert_n[si] = 1'b0;
							end
							done_servo = 1'b1;
						end
					end
					AW_EEP: begin
						if (work.resp_error) begin
							done_servo = 1'b1;
						end else begin
							aw_n = AW_RAM; rb_n[0] = mk_req(RQ_RAM, sid, 8'd0); n = 3'd1;
						end
					end
					AW_RAM: begin
						if (work.resp_error) begin
							done_servo = 1'b1;
						end else begin
							aw_n = AW_TORQUE; rb_n[0] = mk_req(RQ_TORQUE, sid, 8'd0); n = 3'd1;
						end
					end
					AW_TORQUE: begin
						if (!work.resp_error) begin
							miss_n = 4'd0; miss_we = 1'b1; conn_n[si] = 1'b1;
							rb_n[0] = mk_ev(EV_CONNECTED, sid); n = 3'd1;
						end
						done_servo = 1'b1;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		if (done_servo) begin
			if (!tried_q[si]) begin
				tried_n[si] = 1'b1;
				if (!conn_n[si]) begin
					rb_n[n[1:0]] = mk_ev(EV_DISCONNECTED, sid); n = n + 3'd1;
				end
			end
			pidx_n = pidx_q + 4'd1;
			ps = 1'b1;
		end
		// Bus arbitration: a poll step may fall back to the command path.
		if (ps) begin
			if (lvl_q != '0) begin
				pact_n = 1'b0; ppend_n = 1'b1; run_cmd = 1'b1;
			end else if (pidx_n >= cnt_eff) begin
				pact_n = 1'b0; run_cmd = 1'b1;
			end else begin
				ci = pidx_n[SW-1:0];
				if (conn_n[ci]) begin
					aw_n = AW_POLLRAM;
					rb_n[n[1:0]] = mk_req(RQ_RAM, servo_id_list[{3'(ci), 3'b000} +: 8], 8'd0);
				end else begin
					aw_n = AW_PING;
					rb_n[n[1:0]] = mk_req(RQ_PING, servo_id_list[{3'(ci), 3'b000} +: 8], 8'd0);
				end
				n = n + 3'd1;
			end
		end
		if (run_cmd) begin
			if (lvl_q != '0) begin
				cur_n = fifo_head; rd_n = qinc(rd_q); lvl_n = lvl_q - LW'(1);
				aw_n = AW_CMD;
				rb_n[n[1:0]] = mk_req(RQ_CMD, hid, fifo_head[7:0]); n = n + 3'd1;
			end else if (ppend_n) begin
				// A pending poll starts from the current index.
				pact_n = 1'b1; ppend_n = 1'b0;
				if (pidx_n >= cnt_eff) begin
					pact_n = 1'b0; busy_n = 1'b0; aw_n = AW_NONE;
				end else begin
					ci = pidx_n[SW-1:0];
					if (conn_n[ci]) begin
						aw_n = AW_POLLRAM;
						rb_n[n[1:0]] = mk_req(RQ_RAM, servo_id_list[{3'(ci), 3'b000} +: 8], 8'd0);
					end else begin
						aw_n = AW_PING;
						rb_n[n[1:0]] = mk_req(RQ_PING, servo_id_list[{3'(ci), 3'b000} +: 8], 8'd0);
					end
					n = n + 3'd1;
				end
			end else begin
				busy_n = 1'b0; aw_n = AW_NONE;
			end
		end
		rn_n = n;
	end

	// After the id search, the queued EEPROM read finishes via the command path:
	// the next queued command, else a pending poll step.
	result_t search_res;
	result_t next_res;
	always_comb begin
		search_res = found_q ? mk_ev(EV_EEP, cur_q[15:8]) : mk_err(ER_UNKNOWN_ID, cur_q[15:8]);
		if (lvl_q != '0) begin
			next_res = mk_req(RQ_CMD, fifo_head[15:8], fifo_head[7:0]);
		end else begin
			next_res = mk_req(conn_q[si] ? RQ_RAM : RQ_PING, sid, 8'd0);
		end
	end

	assign work_ready = (state_q == ST_DECIDE);
	assign out_valid  = (state_q == ST_EMIT);
	assign res        = rbuf_q[ri_q[1:0]];
	assign last       = (ri_q + 3'd1 == rn_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (work_valid) state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (go_search) state_d = ST_SEARCH;
				else if (rn_n != 3'd0) state_d = ST_EMIT;
				else state_d = ST_IDLE;
			end
			ST_SEARCH: if (sk_q >= cnt_eff || found_q) state_d = ST_EMIT;
			ST_EMIT: if (out_ready && last) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DECIDE && fifo_we) begin
			fifo_mem[wr_q] <= {work.cmd_kind, work.cmd_servo_id, work.cmd_tag};
		end
		if (state_q == ST_DECIDE) begin
			for (int k = 0; k < MaxResults; k++) rbuf_q[k] <= rb_n[k];
		end else if (state_q == ST_SEARCH && (sk_q >= cnt_eff || found_q)) begin
			rbuf_q[0] <= search_res;
			rbuf_q[1] <= next_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			conn_q <= '0; tried_q <= '0; alert_q <= '0;
			for (int k = 0; k < MAX_SERVOS; k++) missed_q[k] <= 4'd0;
			pidx_q <= 4'd0; pact_q <= 1'b0; ppend_q <= 1'b0; busy_q <= 1'b0;
			aw_q <= AW_NONE; rd_q <= '0; wr_q <= '0; lvl_q <= '0; cur_q <= '0;
			rn_q <= 3'd0; ri_q <= 3'd0; sk_q <= 4'd0; found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_DECIDE: begin
					conn_q <= conn_n; tried_q <= tried_n; alert_q <= alert_n;
					if (miss_we) missed_q[si] <= miss_n;
					pidx_q <= pidx_n; pact_q <= pact_n; ppend_q <= ppend_n;
					busy_q <= busy_n; aw_q <= aw_n; rd_q <= rd_n; wr_q <= wr_n;
					lvl_q <= lvl_n; cur_q <= cur_n;
					rn_q <= rn_n; ri_q <= 3'd0; sk_q <= 4'd0; found_q <= 1'b0;
				end
				ST_SEARCH: begin
					if (sk_q >= cnt_eff || found_q) begin
						ri_q <= 3'd0;
						if (lvl_q != '0) begin
							cur_q <= fifo_head; rd_q <= qinc(rd_q);
							lvl_q <= lvl_q - LW'(1); aw_q <= AW_CMD; rn_q <= 3'd2;
						end else if (ppend_q) begin
							ppend_q <= 1'b0;
							if (pidx_q >= cnt_eff) begin
								rn_q <= 3'd1;
								pact_q <= 1'b0; busy_q <= 1'b0; aw_q <= AW_NONE;
							end else begin
								rn_q <= 3'd2;
								pact_q <= 1'b1;
								aw_q <= conn_q[si] ? AW_POLLRAM : AW_PING;
							end
						end else begin
							rn_q <= 3'd1; busy_q <= 1'b0; aw_q <= AW_NONE;
						end
					end else begin
						if (servo_id_list[{sk_q[2:0], 3'b000} +: 8] == cur_q[15:8])
							found_q <= 1'b1;
						else
							sk_q <= sk_q + 4'd1;
					end
				end
				ST_EMIT: if (out_ready) ri_q <= ri_q + 3'd1;
				default: ;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (rn_q != 3'd0 && ri_q < rn_q))
		else $error("emitting beyond result count");
	assert property (@(posedge clk) disable iff (!arst_n)
		32'(lvl_q) <= QUEUE_DEPTH)
		else $error("command queue level overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(aw_q != AW_NONE) |-> busy_q)
		else $error("transfer outstanding while bus free");
	assert property (@(posedge clk) disable iff (!arst_n)
		!(pact_q && ppend_q))
		else $error("poll both active and pending");

endmodule

[hw/rtl/servo_bus_poll_scheduler.sv]
`timescale 1ns / 1ps
// Flow: an accepted input item is registered in the front queue, and the
// back part's sequencer then passes from IDLE through DECIDE to EMIT to offer
// the first result; a queued EEPROM read adds an id search over the servo list.
// The back part's sequencer handles one item at a time: it takes no new item
// until every result of the last one has been taken.
// Reset: arst_n clears all servo state, the poll, the command queue and the
// configuration registers (max_missed returns to three).
module servo_bus_poll_scheduler
	import sbps_pkg::*;
#(
	parameter int unsigned MAX_SERVOS  = MaxServosDef,
	parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic        cmd_kind,
	input  logic [7:0]  cmd_servo_id,
	input  logic [7:0]  cmd_tag,
	input  logic        resp_error,
	input  logic        resp_alert,
	input  logic [15:0] resp_model,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_kind,
	output logic [2:0]  request_kind,
	output logic [2:0]  event_kind,
	output logic [1:0]  err_code,
	output logic [7:0]  servo_id,
	output logic [7:0]  out_tag,
	output logic        last
);

	logic [3:0]  num_servos_q;
	logic [63:0] id_list_q;
	logic [3:0]  max_missed_q;
	logic [15:0] model_q;
	logic        work_valid, work_ready;
	work_t       work;
	result_t     res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_servos_q  <= 4'd0;
			id_list_q     <= 64'd0;
			max_missed_q  <= 4'd3;
			model_q       <= 16'd0;
		end else if (cfg_we) begin
			case (cfg_index_t'({1'b0, cfg_index}))
				CFG_NUM_SERVOS:  num_servos_q  <= cfg_data[3:0];
				CFG_ID_LIST:     id_list_q     <= cfg_data;
				CFG_MAX_MISSED:  max_missed_q  <= cfg_data[3:0];
				CFG_MODEL:       model_q       <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	sbps_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .op, .cmd_kind, .cmd_servo_id,
		.cmd_tag, .resp_error, .resp_alert, .resp_model,
		.expected_model(model_q), .work_valid, .work_ready, .work
	);

	sbps_back #(.MAX_SERVOS(MAX_SERVOS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
		.clk, .arst_n, .work_valid, .work_ready, .work,
		.num_servos(num_servos_q), .servo_id_list(id_list_q),
		.max_missed(max_missed_q), .out_valid, .out_ready, .res, .last
	);

	assign result_kind  = res.result_kind;
	assign request_kind = res.request_kind;
	assign event_kind   = res.event_kind;
	assign err_code     = res.err_code;
	assign servo_id     = res.servo_id;
	assign out_tag      = res.out_tag;

endmodule

[tb/tb_servo_bus_poll_scheduler.sv]
`timescale 1ns / 1ps
module tb_servo_bus_poll_scheduler;
	import sbps_pkg::*;

	typedef struct {
		result_t r;
		logic    lst;
	} bus_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  op;
	logic        cmd_kind;
	logic [7:0]  cmd_servo_id;
	logic [7:0]  cmd_tag;
	logic        resp_error;
	logic        resp_alert;
	logic [15:0] resp_model;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  result_kind;
	logic [2:0]  request_kind;
	logic [2:0]  event_kind;
	logic [1:0]  err_code;
	logic [7:0]  servo_id;
	logic [7:0]  out_tag;
	logic        last;

	servo_bus_poll_scheduler u_dut (.*);

	// Predictor copy of the scheduler state.
	logic [3:0]  m_count;
	logic [63:0] m_ids;
	logic [3:0]  m_max_missed;
	logic [15:0] m_model;
	logic        m_connected [8];
	logic        m_first_tried [8];
	logic        m_alert_seen [8];
	logic [3:0]  m_missed [8];
	logic [3:0]  m_poll_idx;
	logic        m_poll_active;
	logic        m_poll_pending;
	logic        m_bus_busy;
	await_t      m_awaiting;
	logic [16:0] m_fifo [8];
	logic [2:0]  m_rd;
	logic [2:0]  m_wr;
	logic [3:0]  m_level;
	logic [16:0] m_cur_cmd;

	bus_result_t expected_results[$];
	int          fail_count;
	int          quiet_cycles;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          err_pct;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic void add_result(result_kind_t k, logic [2:0] rq, logic [2:0] ev,
			logic [1:0] er, logic [7:0] id, logic [7:0] tag);
		bus_result_t b;
		b.r = '0;
		b.r.result_kind  = k;
		b.r.request_kind = request_kind_t'(rq);
		b.r.event_kind   = event_kind_t'(ev);
		b.r.err_code     = err_code_t'(er);
		b.r.servo_id     = id;
		b.r.out_tag      = tag;
		b.lst            = 1'b0;
		expected_results.push_back(b);
	endfunction

	function automatic int eff_count();
		return (m_count > 8) ? 8 : int'(m_count);
	endfunction

	function automatic logic [7:0] id_at(int i);
		return m_ids[(i % 8) * 8 +: 8];
	endfunction

	function automatic void advance_bus(bit poll_step);
		while (1'b1) begin
			if (poll_step) begin
				if (m_level != 0) begin
					m_poll_active = 1'b0;
					m_poll_pending = 1'b1;
					poll_step = 1'b0;
				end else if (m_poll_idx >= eff_count()) begin
					m_poll_active = 1'b0;
					poll_step = 1'b0;
				end else begin
					if (m_connected[m_poll_idx[2:0]]) begin
						m_awaiting = AW_POLLRAM;
						add_result(RK_REQUEST, RQ_RAM, 3'd0, 2'd0, id_at(m_poll_idx), 8'd0);
					end else begin
						m_awaiting = AW_PING;
						add_result(RK_REQUEST, RQ_PING, 3'd0, 2'd0, id_at(m_poll_idx), 8'd0);
					end
					return;
				end
			end else if (m_level != 0) begin
				m_cur_cmd = m_fifo[m_rd];
				m_rd = m_rd + 3'd1;
				m_level = m_level - 4'd1;
				m_awaiting = AW_CMD;
				add_result(RK_REQUEST, RQ_CMD, 3'd0, 2'd0, m_cur_cmd[15:8], m_cur_cmd[7:0]);
				return;
			end else if (m_poll_pending) begin
				m_poll_active = 1'b1;
				m_poll_pending = 1'b0;
				poll_step = 1'b1;
			end else begin
				m_bus_busy = 1'b0;
				m_awaiting = AW_NONE;
				return;
			end
		end
	endfunction

	function automatic void finish_servo();
		int i;
		i = m_poll_idx % 8;
		if (!m_first_tried[i]) begin
			m_first_tried[i] = 1'b1;
			if (!m_connected[i])
				add_result(RK_EVENT, 3'd0, EV_DISCONNECTED, 2'd0, id_at(i), 8'd0);
		end
		m_poll_idx = m_poll_idx + 4'd1;
		advance_bus(1'b1);
	endfunction

	function automatic void handle_done(logic err, logic alert, logic [15:0] model);
		int i;
		logic [7:0] id;
		logic found;
		i = m_poll_idx % 8;
		id = id_at(i);
		found = 1'b0;
		case (m_awaiting)
			AW_CMD: begin
				if (err) begin
					add_result(RK_ERROR, 3'd0, 3'd0, ER_CMD_FAILED, m_cur_cmd[15:8], 8'd0);
				end else if (m_cur_cmd[16]) begin
					for (int k = 0; k < eff_count(); k++)
						if (id_at(k) == m_cur_cmd[15:8])
							found = 1'b1;
					if (found)
						add_result(RK_EVENT, 3'd0, EV_EEP, 2'd0, m_cur_cmd[15:8], 8'd0);
					else
						add_result(RK_ERROR, 3'd0, 3'd0, ER_UNKNOWN_ID, m_cur_cmd[15:8], 8'd0);
				end
				advance_bus(1'b0);
			end
			AW_PING: begin
				if (err || model != m_model) begin
					finish_servo();
				end else begin
					m_awaiting = AW_EEP;
					add_result(RK_REQUEST, RQ_EEP, 3'd0, 2'd0, id, 8'd0);
				end
			end
			AW_POLLRAM: begin
				if (err) begin
					if (m_missed[i] < MissSat)
						m_missed[i] = m_missed[i] + 4'd1;
					if (m_missed[i] >= m_max_missed) begin
						m_connected[i] = 1'b0;
						add_result(RK_EVENT, 3'd0, EV_DISCONNECTED, 2'd0, id, 8'd0);
					end
					finish_servo();
				end else if (m_level != 0) begin
					// The reply is dropped; this servo is polled again after the queue.
					m_poll_active = 1'b0;
					m_poll_pending = 1'b1;
					advance_bus(1'b0);
				end else begin
					m_missed[i] = 4'd0;
					add_result(RK_EVENT, 3'd0, EV_RAM, 2'd0, id, 8'd0);
					if (alert) begin
						if (!m_alert_seen[i]) begin
							add_result(RK_EVENT, 3'd0, EV_ALERT, 2'd0, id, 8'd0);
							m_alert_seen[i] = 1'b1;
						end
					end else begin
						m_alert_seen[i] = 1'b0;
					end
					finish_servo();
				end
			end
			AW_EEP: begin
				if (err) begin
					finish_servo();
				end else begin
					m_awaiting = AW_RAM;
					add_result(RK_REQUEST, RQ_RAM, 3'd0, 2'd0, id, 8'd0);
				end
			end
			AW_RAM: begin
				if (err) begin
					finish_servo();
				end else begin
					m_awaiting = AW_TORQUE;
					add_result(RK_REQUEST, RQ_TORQUE, 3'd0, 2'd0, id, 8'd0);
				end
			end
			AW_TORQUE: begin
				if (!err) begin
					m_missed[i] = 4'd0;
					m_connected[i] = 1'b1;
					add_result(RK_EVENT, 3'd0, EV_CONNECTED, 2'd0, id, 8'd0);
				end
				finish_servo();
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void predict_item(op_t o, logic k, logic [7:0] id, logic [7:0] tag,
			logic err, logic alert, logic [15:0] model);
		int before_n;
		before_n = expected_results.size();
		case (o)
			OP_TICK: begin
				if (m_poll_active || m_poll_pending) begin
					add_result(RK_ERROR, 3'd0, 3'd0, ER_OVERRUN, 8'd0, 8'd0);
				end else begin
					m_poll_idx = 4'd0;
					if (!m_bus_busy) begin
						m_bus_busy = 1'b1;
						m_poll_active = 1'b1;
						advance_bus(1'b1);
					end else begin
						m_poll_pending = 1'b1;
					end
				end
			end
			OP_ENQUEUE: begin
				if (m_level >= 8) begin
					add_result(RK_ERROR, 3'd0, 3'd0, ER_QUEUE_FULL, id, 8'd0);
				end else begin
					m_fifo[m_wr] = {k, id, tag};
					m_wr = m_wr + 3'd1;
					m_level = m_level + 4'd1;
					if (!m_bus_busy) begin
						m_bus_busy = 1'b1;
						advance_bus(1'b0);
					end
				end
			end
			OP_DONE: handle_done(err, alert, model);
			default: begin
			end
		endcase
		if (expected_results.size() > before_n)
			expected_results[expected_results.size() - 1].lst = 1'b1;
	endfunction

	function automatic void check_field(string name, int e, int a);
		if (e != a) begin
			$error("%s: expected %0d, got %0d", name, e, a);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		bus_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("result with nothing expected: result_kind %0d servo_id %0d",
					result_kind, servo_id);
				fail_count++;
			end else begin
				e = expected_results.pop_front();
				check_field("result_kind", e.r.result_kind, result_kind);
				check_field("request_kind", e.r.request_kind, request_kind);
				check_field("event_kind", e.r.event_kind, event_kind);
				check_field("err_code", e.r.err_code, err_code);
				check_field("servo_id", e.r.servo_id, servo_id);
				check_field("out_tag", e.r.out_tag, out_tag);
				check_field("last", e.lst, last);
			end
		end
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	// Ends a hung run: counts cycles with no item moving on either side.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= 20000) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(cfg_index_t idx, logic [63:0] value);
		@(negedge clk);
		in_valid <= 1'b0;
		cfg_we <= 1'b1;
		cfg_index <= idx[1:0];
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_NUM_SERVOS:  m_count = value[3:0];
			CFG_ID_LIST:     m_ids = value;
			CFG_MAX_MISSED:  m_max_missed = value[3:0];
			CFG_MODEL:       m_model = value[15:0];
			default: begin
			end
		endcase
	endtask

	task automatic send_item(op_t o, logic k, logic [7:0] id, logic [7:0] tag,
			logic err, logic alert, logic [15:0] model);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		cmd_kind <= k;
		cmd_servo_id <= id;
		cmd_tag <= tag;
		resp_error <= err;
		resp_alert <= alert;
		resp_model <= model;
		do
			@(posedge clk);
		while (!(in_valid && in_ready));
		predict_item(o, k, id, tag, err, alert, model);
	endtask

	task automatic send_done(logic err, logic alert, logic [15:0] model);
		send_item(OP_DONE, 1'($urandom_range(1)), 8'($urandom_range(255)),
			8'($urandom_range(255)), err, alert, model);
	endtask

	// The sender holds back until every expected result has come.
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// Answers every outstanding transfer so that the block comes to rest.
	task automatic settle();
		while (m_awaiting != AW_NONE)
			send_done($urandom_range(99) < err_pct, 1'($urandom_range(1)), m_model);
		wait_drained();
		repeat (30) @(posedge clk);
	endtask

	task automatic test_bring_up();
		write_reg(CFG_NUM_SERVOS, 64'd2);
		write_reg(CFG_ID_LIST, 64'hFFFF_FFFF_FFFF_FF00);
		write_reg(CFG_MAX_MISSED, 64'd1);
		write_reg(CFG_MODEL, 64'hFFFF);
		send_done(1'b0, 1'b0, 16'h0);
		send_item(OP_NONE, 1'b1, 8'hFF, 8'hFF, 1'b1, 1'b1, 16'hFFFF);
		send_item(OP_TICK, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 16'h0);
		send_done(1'b0, 1'b0, 16'h0000);
		send_item(OP_TICK, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 16'h0);
		repeat (4) send_done(1'b0, 1'b0, 16'hFFFF);
		send_item(OP_TICK, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 16'h0);
		repeat (2) send_done(1'b0, 1'b1, 16'hFFFF);
		send_item(OP_TICK, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 16'h0);
		send_done(1'b0, 1'b1, 16'hFFFF);
		send_done(1'b1, 1'b0, 16'hFFFF);
		settle();
	endtask

	task automatic test_queue();
		send_item(OP_TICK, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 16'h0);
		// Nine commands behind a busy bus: the last finds the queue full.
		for (int n = 0; n < 9; n++)
			send_item(OP_ENQUEUE, n[0], (n == 2) ? 8'h55 : 8'hFF, 8'(n * 31), 1'b0, 1'b0,
				16'h0);
		send_done(1'b0, 1'b0, 16'hFFFF);
		send_done(1'b1, 1'b0, 16'h0);
		wait_drained();
		settle();
	endtask

	task automatic test_random(int idle, int stall, int n_items);
		int done_items;
		op_t o;
		logic [7:0] id;
		send_idle_pct = idle;
		recv_stall_pct = stall;
		done_items = 0;
		while (done_items < n_items) begin
			id = ($urandom_range(3) != 0) ? id_at($urandom_range(7)) : 8'($urandom_range(255));
			if (m_awaiting != AW_NONE && $urandom_range(99) < 60) begin
				send_done($urandom_range(99) < err_pct, 1'($urandom_range(1)),
					($urandom_range(4) != 0) ? m_model : 16'($urandom));
				done_items++;
			end else begin
				case ($urandom_range(19))
					0, 1, 2, 3, 4, 5, 6: o = OP_TICK;
					7: o = OP_NONE;
					8: o = OP_DONE;
					default: o = OP_ENQUEUE;
				endcase
				if (o == OP_TICK || o == OP_ENQUEUE || (o == OP_DONE && m_awaiting != AW_NONE))
					done_items++;
				send_item(o, 1'($urandom_range(1)), id, 8'($urandom_range(255)),
					1'($urandom_range(1)), 1'($urandom_range(1)), 16'($urandom));
			end
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		op = OP_NONE;
		cmd_kind = 1'b0;
		cmd_servo_id = '0;
		cmd_tag = '0;
		resp_error = 1'b0;
		resp_alert = 1'b0;
		resp_model = '0;
		out_ready = 1'b0;
		fail_count = 0;
		quiet_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		err_pct = 25;
		m_count = 0;
		m_ids = '0;
		m_max_missed = 4'd3;
		m_model = '0;
		for (int i = 0; i < 8; i++) begin
			m_connected[i] = 1'b0;
			m_first_tried[i] = 1'b0;
			m_alert_seen[i] = 1'b0;
			m_missed[i] = '0;
			m_fifo[i] = '0;
		end
		m_poll_idx = '0;
		m_poll_active = 1'b0;
		m_poll_pending = 1'b0;
		m_bus_busy = 1'b0;
		m_awaiting = AW_NONE;
		m_rd = '0;
		m_wr = '0;
		m_level = '0;
		m_cur_cmd = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_bring_up();
		test_queue();

		write_reg(CFG_NUM_SERVOS, 64'd8);
		write_reg(CFG_ID_LIST, {$urandom, $urandom});
		write_reg(CFG_MAX_MISSED, 64'd15);
		write_reg(CFG_MODEL, 64'h0000);
		err_pct = 50;
		test_random(0, 0, 50);

		write_reg(CFG_NUM_SERVOS, 64'd0);
		err_pct = 20;
		test_random(67, 0, 25);

		write_reg(CFG_NUM_SERVOS, 64'd5);
		write_reg(CFG_ID_LIST, {$urandom, $urandom});
		write_reg(CFG_MAX_MISSED, 64'd1);
		write_reg(CFG_MODEL, 64'($urandom_range(65535)));
		test_random(0, 67, 50);

		write_reg(CFG_NUM_SERVOS, 64'd8);
		write_reg(CFG_MAX_MISSED, 64'd3);
		write_reg(CFG_MODEL, 64'hFFFF);
		err_pct = 30;
		test_random(23, 23, 80);

		@(negedge clk);
		in_valid <= 1'b0;
		wait_drained();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
